>>> sv/ssoc_pkg.sv
// ssoc_pkg: shared constants and types for the substring occurrence counter
// used by ssoc_cell and substring_occurrence_counter, no dependencies

package ssoc_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 16;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2
   } cmd_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic shift_text;
      logic clear_text;
      logic shift_pat;
      logic clear_pat;
   } cell_ctrl_type;

endpackage

>>> sv/ssoc_cell.sv
// ssoc_cell: one position of the pattern/window chain
// holds one text byte and one pattern byte, compares the pattern byte with the incoming text byte; uses ssoc_pkg

module ssoc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ssoc_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              text_byte_in,
   input  logic                    text_valid_in,
   input  logic [7:0]              pat_byte_in,
   input  logic                    pat_active_in,
   output logic [7:0]              text_byte_out,
   output logic                    text_valid_out,
   output logic [7:0]              pat_byte_out,
   output logic                    pat_active_out,
   output logic                    cell_ok,
   output logic                    cell_short
);

   logic [7:0] text_byte_ff;
   logic [7:0] text_byte_in_w;
   logic       text_valid_ff;
   logic       text_valid_in_w;
   logic [7:0] pat_byte_ff;
   logic [7:0] pat_byte_in_w;
   logic       pat_active_ff;
   logic       pat_active_in_w;

   always_comb begin
      text_byte_in_w  = ctrl.shift_text ? text_byte_in : text_byte_ff;
      priority if (ctrl.clear_text) begin
         text_valid_in_w = 1'b0;
      end else if (ctrl.shift_text) begin
         text_valid_in_w = text_valid_in;
      end else begin
         text_valid_in_w = text_valid_ff;
      end
      pat_byte_in_w   = ctrl.shift_pat ? pat_byte_in : pat_byte_ff;
      priority if (ctrl.clear_pat) begin
         pat_active_in_w = 1'b0;
      end else if (ctrl.shift_pat) begin
         pat_active_in_w = pat_active_in;
      end else begin
         pat_active_in_w = pat_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      text_byte_ff <= text_byte_in_w;
      pat_byte_ff  <= pat_byte_in_w;
      if (reset) begin
         text_valid_ff <= 1'b0;
         pat_active_ff <= 1'b0;
      end else begin
         text_valid_ff <= text_valid_in_w;
         pat_active_ff <= pat_active_in_w;
      end
   end

   // compare against the byte this cell receives on the current text shift
   assign cell_ok    = !pat_active_ff || (text_valid_in && (pat_byte_ff == text_byte_in));
   assign cell_short = pat_active_ff && !text_valid_in;

   assign text_byte_out  = text_byte_ff;
   assign text_valid_out = text_valid_ff;
   assign pat_byte_out   = pat_byte_ff;
   assign pat_active_out = pat_active_ff;

endmodule

>>> sv/substring_occurrence_counter.sv
// substring_occurrence_counter: top level, a chain of ssoc_cell plus count and result register
// uses ssoc_pkg and ssoc_cell

// Takes one item per clock cycle, back to back, while the result register is
// free or being taken, and presents a result in the cycle after the text byte
// marked last. The pattern is held reversed in a chain of 64 cells beside the
// text window, so appending a byte and streaming a text byte are both one shift
// of the chain; every cell compares its pair in the same cycle and the 64
// results are AND-ed with the saturating count update, which sets the cycle's
// longest path. A registered output stage holds each result until it is taken, and no new item enters while it waits.

module substring_occurrence_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_match_count,
   output logic        rsp_text_shorter,
   output logic        rsp_pattern_truncated
);

   localparam int N = ssoc_pkg::PATTERN_MAX;

   ssoc_pkg::cell_ctrl_type ctrl;
   ssoc_pkg::cmd_type       cmd;

   logic [N-1:0][7:0] text_byte;
   logic [N-1:0]      text_valid;
   logic [N-1:0][7:0] pat_byte;
   logic [N-1:0]      pat_active;
   logic [N-1:0]      cell_ok;
   logic [N-1:0]      cell_short;

   logic        accept;
   logic        is_text;
   logic        is_append;
   logic        is_clear;
   logic        emit;
   logic        match;
   logic        shorter;

   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic [15:0] count_next;
   logic        trunc_ff;
   logic        trunc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_count_ff;
   logic        rsp_short_ff;
   logic        rsp_trunc_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = ssoc_pkg::cmd_type'(req_cmd);

   always_comb begin
      is_text   = 1'b0;
      is_append = 1'b0;
      is_clear  = 1'b0;
      unique case (cmd)
         ssoc_pkg::CMD_CLEAR:  is_clear  = 1'b1;
         ssoc_pkg::CMD_APPEND: is_append = 1'b1;
         ssoc_pkg::CMD_TEXT:   is_text   = 1'b1;
         default: ;
      endcase
   end

   assign emit = accept && is_text && req_last;

   always_comb begin
      ctrl.shift_text = accept && is_text;
      ctrl.clear_text = accept && (is_clear || is_append || (is_text && req_last));
      // a full chain drops the byte
      ctrl.shift_pat  = accept && is_append && !pat_active[N-1];
      ctrl.clear_pat  = accept && is_clear;
   end

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_cell
         logic [7:0] t_in;
         logic       v_in;
         logic [7:0] p_in;
         logic       a_in;
         if (k == 0) begin : g_head
            assign t_in = req_data_byte;
            assign v_in = 1'b1;
            assign p_in = req_data_byte;
            assign a_in = 1'b1;
         end else begin : g_body
            assign t_in = text_byte[k-1];
            assign v_in = text_valid[k-1];
            assign p_in = pat_byte[k-1];
            assign a_in = pat_active[k-1];
         end
         ssoc_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctrl           (ctrl),
            .text_byte_in   (t_in),
            .text_valid_in  (v_in),
            .pat_byte_in    (p_in),
            .pat_active_in  (a_in),
            .text_byte_out  (text_byte[k]),
            .text_valid_out (text_valid[k]),
            .pat_byte_out   (pat_byte[k]),
            .pat_active_out (pat_active[k]),
            .cell_ok        (cell_ok[k]),
            .cell_short     (cell_short[k])
         );
      end
   endgenerate

   // empty pattern never matches
   assign match   = pat_active[0] && (&cell_ok);
   assign shorter = |cell_short;

   assign count_next = (match && (count_ff != 16'hFFFF)) ? count_ff + 16'd1 : count_ff;

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear_text) begin
         count_in = 16'd0;
      end else if (ctrl.shift_text) begin
         count_in = count_next;
      end
      priority if (ctrl.clear_pat) begin
         trunc_in = 1'b0;
      end else if (accept && is_append && pat_active[N-1]) begin
         trunc_in = 1'b1;
      end else begin
         trunc_in = trunc_ff;
      end
   end

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 16'd0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_count_ff <= count_next;
         rsp_short_ff <= shorter;
         rsp_trunc_ff <= trunc_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_match_count       = rsp_count_ff;
   assign rsp_text_shorter      = rsp_short_ff;
   assign rsp_pattern_truncated = rsp_trunc_ff;

endmodule

>>> dv/tb_substring_occurrence_counter.sv
// tb_substring_occurrence_counter: self-checking testbench for the substring occurrence counter
// drives pattern and text transfers with random idling and checks every count result
// depends on ssoc_pkg and substring_occurrence_counter

`timescale 1ns / 100ps

module tb_substring_occurrence_counter;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         COUNT_SAT      = 65535;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         PHASE_ITEMS    = 85;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [15:0] count;
      logic        shorter;
      logic        truncated;
   } count_result_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd         = ssoc_pkg::CMD_CLEAR;
   logic [7:0]  req_data_byte   = 8'h00;
   logic        req_last        = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [15:0] rsp_match_count;
   logic        rsp_text_shorter;
   logic        rsp_pattern_truncated;

   substring_occurrence_counter DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_data_byte         (req_data_byte),
      .req_last              (req_last),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_match_count       (rsp_match_count),
      .rsp_text_shorter      (rsp_text_shorter),
      .rsp_pattern_truncated (rsp_pattern_truncated)
   );

   req_item_type     pending_reqs [$];
   count_result_type expected_counts [$];
   req_item_type     next_req;
   count_result_type oldest_count;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int phase_items = 0;

   // shadow of the counter state
   logic [7:0] pat_mem [ssoc_pkg::PATTERN_MAX];
   logic [7:0] win_mem [ssoc_pkg::PATTERN_MAX];
   int         pat_len;
   int         text_len;
   int         occurrences;
   logic       dropped;

   // stimulus side copy of the loaded pattern, used to plant matches
   logic [7:0] loaded_pat [$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic clear_text_state();
      for (int i = 0; i < ssoc_pkg::PATTERN_MAX; i++) win_mem[i] = 8'h00;
      text_len = 0;
      occurrences = 0;
   endtask

   function automatic bit window_hit();
      if (pat_len == 0 || text_len < pat_len) return 1'b0;
      for (int j = 0; j < pat_len; j++)
         if (pat_mem[j] != win_mem[pat_len - 1 - j]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_count(input logic [1:0] cmd, input logic [7:0] data,
                                input logic last);
      count_result_type res;
      if (cmd == ssoc_pkg::CMD_CLEAR) begin
         pat_len = 0;
         dropped = 1'b0;
         clear_text_state();
      end else if (cmd == ssoc_pkg::CMD_APPEND) begin
         if (pat_len < ssoc_pkg::PATTERN_MAX) begin
            pat_mem[pat_len] = data;
            pat_len++;
         end else begin
            dropped = 1'b1;
         end
         clear_text_state();
      end else if (cmd == ssoc_pkg::CMD_TEXT) begin
         for (int i = ssoc_pkg::PATTERN_MAX - 1; i > 0; i--) win_mem[i] = win_mem[i - 1];
         win_mem[0] = data;
         if (text_len < COUNT_SAT) text_len++;
         if (window_hit() && occurrences < COUNT_SAT) occurrences++;
         if (last) begin
            res.count     = occurrences[15:0];
            res.shorter   = (text_len < pat_len);
            res.truncated = dropped;
            expected_counts.push_back(res);
            clear_text_state();
         end
      end
   endtask

   // driver: present the next queued item once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_count(req_cmd, req_data_byte, req_last);
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_valid     <= 1'b1;
               req_cmd       <= next_req.cmd;
               req_data_byte <= next_req.data;
               req_last      <= next_req.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transfer against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $error("result transfer with no expected count, match_count %0d",
                      rsp_match_count);
               fail_count++;
            end else begin
               oldest_count = expected_counts.pop_front();
               if (rsp_match_count !== oldest_count.count) begin
                  $error("match_count expected %0d actual %0d",
                         oldest_count.count, rsp_match_count);
                  fail_count++;
               end
               if (rsp_text_shorter !== oldest_count.shorter) begin
                  $error("text_shorter expected %0b actual %0b",
                         oldest_count.shorter, rsp_text_shorter);
                  fail_count++;
               end
               if (rsp_pattern_truncated !== oldest_count.truncated) begin
                  $error("pattern_truncated expected %0b actual %0b",
                         oldest_count.truncated, rsp_pattern_truncated);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** substring_occurrence_counter: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_req(input logic [1:0] cmd, input logic [7:0] data, input logic last);
      req_item_type it;
      it.cmd  = cmd;
      it.data = data;
      it.last = last;
      pending_reqs.push_back(it);
      if (cmd != CMD_UNUSED) phase_items++;
   endtask

   task automatic push_append(input logic [7:0] data);
      push_req(ssoc_pkg::CMD_APPEND, data, 1'($urandom_range(1)));
      if (loaded_pat.size() < ssoc_pkg::PATTERN_MAX) loaded_pat.push_back(data);
   endtask

   // text of len bytes, mostly from a two-symbol alphabet with planted pattern copies
   task automatic push_text(input int len, input logic [7:0] sym0, input logic [7:0] sym1,
                            input bit with_last);
      logic [7:0] seq [$];
      int         k;
      while (seq.size() < len) begin
         if (loaded_pat.size() > 0 && $urandom_range(1) == 1) begin
            for (k = 0; k < loaded_pat.size() && seq.size() < len; k++)
               seq.push_back(loaded_pat[k]);
         end else if ($urandom_range(9) == 0) begin
            seq.push_back(8'($urandom_range(255)));
         end else begin
            seq.push_back($urandom_range(1) ? sym1 : sym0);
         end
      end
      for (k = 0; k < len; k++) begin
         if ($urandom_range(99) < 3)
            push_req(CMD_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)));
         push_req(ssoc_pkg::CMD_TEXT, seq[k], with_last && (k == len - 1));
      end
   endtask

   task automatic push_session();
      logic [7:0] sym0;
      logic [7:0] sym1;
      int         plen;
      int         ntexts;
      int         tlen;
      int         r;
      sym0 = 8'($urandom_range(255));
      sym1 = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 5) plen = 0;
      else if (r < 75) plen = $urandom_range(4, 1);
      else if (r < 90) plen = $urandom_range(16, 5);
      else plen = $urandom_range(70, 60);
      push_req(ssoc_pkg::CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      loaded_pat.delete();
      for (int i = 0; i < plen; i++) push_append($urandom_range(1) ? sym1 : sym0);
      ntexts = $urandom_range(4, 1);
      for (int t = 0; t < ntexts; t++) begin
         // pattern change in the middle of a text
         if ($urandom_range(9) == 0) begin
            push_text($urandom_range(5, 1), sym0, sym1, 1'b0);
            push_append($urandom_range(1) ? sym1 : sym0);
         end
         plen = loaded_pat.size();
         if (plen > 1 && $urandom_range(99) < 15) tlen = $urandom_range(plen - 1, 1);
         else if (plen == 0) tlen = $urandom_range(12, 1);
         else tlen = plen + $urandom_range(20);
         push_text(tlen, sym0, sym1, 1'b1);
      end
      // unterminated text, dropped by the next clear
      if ($urandom_range(4) == 0) push_text($urandom_range(6, 1), sym0, sym1, 1'b0);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_counts.size() != 0);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      pat_len = 0;
      dropped = 1'b0;
      clear_text_state();
      for (int i = 0; i < ssoc_pkg::PATTERN_MAX; i++) pat_mem[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pattern, ignored commands, overlap, short text, mid-text change
      set_idling(0, 0);
      push_req(ssoc_pkg::CMD_TEXT, 8'h00, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hFF, 1'b1);
      push_req(CMD_UNUSED, 8'hFF, 1'b1);
      push_req(ssoc_pkg::CMD_APPEND, 8'hAA, 1'b1);
      push_req(ssoc_pkg::CMD_APPEND, 8'hAA, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hAA, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hAA, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hAA, 1'b1);
      push_req(ssoc_pkg::CMD_TEXT, 8'hAA, 1'b1);
      push_req(ssoc_pkg::CMD_TEXT, 8'h55, 1'b0);
      push_req(ssoc_pkg::CMD_APPEND, 8'h00, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hAA, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hAA, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'h00, 1'b1);
      push_req(ssoc_pkg::CMD_CLEAR, 8'hFF, 1'b1);
      push_req(ssoc_pkg::CMD_TEXT, 8'hFF, 1'b1);
      push_req(ssoc_pkg::CMD_APPEND, 8'hFF, 1'b0);
      push_req(ssoc_pkg::CMD_APPEND, 8'h00, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'hFF, 1'b0);
      push_req(ssoc_pkg::CMD_TEXT, 8'h00, 1'b1);
      wait_drained();

      // random sessions, cycling through the idling mixes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: set_idling(0, 0);
            1: set_idling(56, 0);
            2: set_idling(0, 56);
            default: set_idling(31, 31);
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) push_session();
         wait_drained();
      end

      // full pattern with dropped bytes
      set_idling(0, 0);
      push_req(ssoc_pkg::CMD_CLEAR, 8'h00, 1'b0);
      loaded_pat.delete();
      for (int i = 0; i < ssoc_pkg::PATTERN_MAX + 2; i++)
         push_append(8'($urandom_range(255)));
      for (int i = 0; i < ssoc_pkg::PATTERN_MAX; i++)
         push_req(ssoc_pkg::CMD_TEXT, loaded_pat[i], i == ssoc_pkg::PATTERN_MAX - 1);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("** substring_occurrence_counter: PASSED **");
      end else begin
         $display("** substring_occurrence_counter: FAILED **");
      end
      $finish;
   end

endmodule
